// ===== rtl/core/arcl_pkg.sv =====
// Shared types and constants for the address range country lookup block.
// Used by the controller, the datapath and the top level; depends on nothing.
package arcl_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths.
    localparam int ADDR_W     = 32;
    localparam int ACOUNT_W   = 33;
    localparam int CODE_W     = 16;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int S_FIELDS_W = ADDR_W + ACOUNT_W + CODE_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = CODE_W;

    // Operation codes carried in the input tuser.
    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 2'd0,
        FN_LOOKUP = 2'd1,
        FN_CLEAR  = 2'd2
    } t_func;

    // Result status codes carried in the output tuser.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    // One table entry as stored in the range memory.
    typedef struct packed {
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] end_addr;
        logic [CODE_W-1:0] code;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the accepted item and restart the scan
        logic scan;    // step the table scan by one entry
        logic finish;  // update the table and load the output register
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;  // every occupied entry has been read and evaluated
        logic out_free;   // the output register can take a result this cycle
    } t_ctrl_sts;

endpackage

// ===== rtl/core/arcl_ctrl.sv =====
// Controller state machine of the address range country lookup block.
// Depends on arcl_pkg; drives the datapath in arcl_dpath through t_ctrl_cmd.
module arcl_ctrl
    import arcl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_ctrl_sts i_sts,
    output t_ctrl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/arcl_dpath.sv =====
// Datapath of the address range country lookup block: range memory, fill
// count, scan pipeline, match logic and output register. Depends on arcl_pkg.
module arcl_dpath
    import arcl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctrl_cmd            i_cmd,
    output t_ctrl_sts            o_sts,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic [FUNC_W-1:0]    i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,
    output logic [STATUS_W-1:0]  o_m_tuser
);

    // Range memory; entries at and above the fill count are unused.
    t_entry r_mem [TABLE_DEPTH];

    // Control state.
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] r_idx;
    logic             r_rd_vld;
    logic             r_out_vld;

    // Item and scan payload.
    logic [FUNC_W-1:0]   r_func;
    logic [ADDR_W-1:0]   r_addr;
    logic [ADDR_W-1:0]   r_end;
    logic [CODE_W-1:0]   r_code;
    t_entry              r_rd_data;
    logic [IDX_W-1:0]    r_rd_idx;
    logic                r_hit;
    logic [IDX_W-1:0]    r_hit_idx;
    logic                r_found;
    logic [ADDR_W-1:0]   r_best_start;
    logic [CODE_W-1:0]   r_best_code;
    logic [STATUS_W-1:0] r_out_status;
    logic [CODE_W-1:0]   r_out_code;

    // Input field unpacking.
    logic [ADDR_W-1:0]   in_addr;
    logic [ACOUNT_W-1:0] in_count;
    logic [CODE_W-1:0]   in_code;
    logic [ADDR_W+1:0]   end_sum;
    logic [ADDR_W-1:0]   n_end;

    assign in_addr  = i_s_tdata[ADDR_W-1:0];
    assign in_count = i_s_tdata[ADDR_W+ACOUNT_W-1:ADDR_W];
    assign in_code  = i_s_tdata[S_FIELDS_W-1:ADDR_W+ACOUNT_W];

    // Inclusive end; a zero count means a single address, overflow saturates.
    always_comb begin
        if (in_count == '0) begin
            end_sum = {2'b00, in_addr};
        end else begin
            end_sum = {2'b00, in_addr} + {1'b0, in_count} - (ADDR_W + 2)'(1);
        end
        n_end = (end_sum[ADDR_W+1:ADDR_W] != 2'b00) ? '1 : end_sum[ADDR_W-1:0];
    end

    // Scan read and match evaluation.
    logic rd_issue;
    logic match_same;
    logic in_range;
    logic better;

    assign rd_issue   = i_cmd.scan && (r_idx < r_fill);
    assign match_same = r_rd_data.start_addr == r_addr;
    assign in_range   = (r_rd_data.start_addr <= r_addr) && (r_addr <= r_rd_data.end_addr);
    assign better     = !r_found || (r_rd_data.start_addr < r_best_start);

    // Table update and result at finish.
    logic                has_room;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_idx;
    logic                fill_inc;
    logic                fill_clr;
    logic [STATUS_W-1:0] n_status;
    logic [CODE_W-1:0]   n_code;

    assign has_room = r_fill < CNT_W'(TABLE_DEPTH);

    always_comb begin
        wr_en    = 1'b0;
        wr_idx   = r_hit_idx;
        fill_inc = 1'b0;
        fill_clr = 1'b0;
        n_status = ST_OK;
        n_code   = '0;
        case (r_func)
            FN_INSERT: begin
                if (r_hit) begin
                    wr_en = 1'b1;
                end else if (has_room) begin
                    wr_en    = 1'b1;
                    wr_idx   = r_fill[IDX_W-1:0];
                    fill_inc = 1'b1;
                end else begin
                    n_status = ST_FULL;
                end
            end
            FN_LOOKUP: begin
                if (r_found) begin
                    n_code = r_best_code;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            FN_CLEAR: begin
                fill_clr = 1'b1;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Memory port: one read and one write per cycle.
    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_rd_data <= r_mem[r_idx[IDX_W-1:0]];
        end
        if (i_cmd.finish && wr_en) begin
            r_mem[wr_idx] <= '{start_addr: r_addr, end_addr: r_end, code: r_code};
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (rd_issue) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            r_rd_vld <= rd_issue;
            if (i_cmd.finish && fill_clr) begin
                r_fill <= '0;
            end else if (i_cmd.finish && fill_inc) begin
                r_fill <= r_fill + CNT_W'(1);
            end
            if (i_cmd.finish) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_s_tuser;
            r_addr  <= in_addr;
            r_end   <= n_end;
            r_code  <= in_code;
            r_hit   <= 1'b0;
            r_found <= 1'b0;
        end else if (r_rd_vld) begin
            // Insert keeps the first entry with the same start.
            if (!r_hit && match_same) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_rd_idx;
            end
            // Lookup keeps the covering range with the lowest start.
            if (in_range && better) begin
                r_found      <= 1'b1;
                r_best_start <= r_rd_data.start_addr;
                r_best_code  <= r_rd_data.code;
            end
        end
        if (rd_issue) begin
            r_rd_idx <= r_idx[IDX_W-1:0];
        end
        if (i_cmd.finish) begin
            r_out_status <= n_status;
            r_out_code   <= n_code;
        end
    end

    assign o_sts.scan_done = (r_idx == r_fill) && !r_rd_vld;
    assign o_sts.out_free  = !r_out_vld || i_m_tready;

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_code;
    assign o_m_tuser  = r_out_status;

    // The fill count never passes the table depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(TABLE_DEPTH))
        else $error("fill count above table depth");

    // While scanning, the pointer never runs past the occupied part of the table.
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> (r_idx <= r_fill))
        else $error("scan index beyond fill count");

    // A result is never loaded over one that is still waiting to be taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_out_vld || i_m_tready))
        else $error("result register overwritten");

    // Read data is only evaluated for reads issued by the scan.
    a_rd_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> $past(i_cmd.scan))
        else $error("read data without scan step");

endmodule

// ===== rtl/core/address_range_country_lookup_top.sv =====
// Top level of the address range country lookup block.
// Depends on arcl_pkg, arcl_ctrl and arcl_dpath.
//
// This block keeps a table of up to TABLE_DEPTH (4096) IPv4 address ranges,
// each with an inclusive start, an inclusive end and a two-letter country
// code, and serves one operation per input transfer: insert a range (replace
// the entry with the same start or append a new one, reporting a full table),
// look up an address (return the code of the covering range with the lowest
// start, or not found), or clear the table. Every operation produces exactly
// one output transfer. Occupied entries always form a contiguous block from
// entry 0, tracked by a fill count, so reset and clear take effect at once and
// the memory needs no clearing pass. Each item scans the occupied entries at
// one read per cycle from the range memory, and the block takes no new item
// until every occupied entry has been read and evaluated. The result sits in
// an output register, so the next item is accepted while a result still
// waits to be taken downstream.
module address_range_country_lookup_top
    import arcl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input stream.
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // tdata, lowest bit up: address (32), address_count (33), code_in (16),
    // zero padding (7).
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // tuser: func (2).
    input  logic [FUNC_W-1:0]    i_s_axis_tuser,
    // Output stream.
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // tdata: code_out (16).
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    // tuser: status (2).
    output logic [STATUS_W-1:0]  o_m_axis_tuser
);

    t_ctrl_cmd cmd;
    t_ctrl_sts sts;

    // The controller sequences capture, scan and finish of one item at a time.
    arcl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // The datapath holds the table, evaluates entries and owns the result
    // register that drives the output transfer.
    arcl_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tuser  (i_s_axis_tuser),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tuser  (o_m_axis_tuser)
    );

endmodule
